// ----- rtl/sfd_pkg.sv -----
// Shared types and constants for the serial frame deframer.
// No dependencies; imported by the parser, output stage and top level.
package sfd_pkg;

    // parser phase codes
    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_LEN_HI  = 4'd1;
    localparam logic [3:0] PH_LEN_LO  = 4'd2;
    localparam logic [3:0] PH_HDR0    = 4'd3;
    localparam logic [3:0] PH_HDR5    = 4'd8;
    localparam logic [3:0] PH_PAYLOAD = 4'd9;
    localparam logic [3:0] PH_CHECK   = 4'd10;
    localparam logic [3:0] PH_END     = 4'd11;

    localparam int HDR_BYTES = 6;

    // configuration register indexes
    localparam logic [1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [1:0] CFG_END_BYTE    = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0] START_BYTE_RST  = 8'h02;
    localparam logic [7:0] END_BYTE_RST    = 8'h03;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd99;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    // error mask bits
    localparam int ERR_START = 0;
    localparam int ERR_END   = 1;
    localparam int ERR_SUM   = 2;
    localparam int ERR_LONG  = 3;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic        kind;
        byte_t       data_byte;
        byte_t       byte_index;
        logic [15:0] length;
        byte_t       cmd;
        byte_t       dev_id;
        byte_t       dev_address;
        byte_t       dev_channel;
        byte_t       mode_byte;
        byte_t       response_time;
        logic [3:0]  error_mask;
    } result_t;

endpackage

// ----- rtl/sfd_parser.sv -----
// Frame parser: configuration registers, phase state machine and result build.
// Depends on sfd_pkg.
module sfd_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic           in_accept,
    input  logic [7:0]     in_byte,
    output logic           res_valid,
    output sfd_pkg::result_t res
);
    import sfd_pkg::*;

    byte_t       start_byte_reg, end_byte_reg, max_payload_reg;
    logic [3:0]  phase_reg, phase_next;
    byte_t       count_reg, count_next;
    logic [15:0] len_reg, len_next;
    byte_t       hdr_reg [HDR_BYTES];
    byte_t       hdr_next [HDR_BYTES];
    byte_t       xor_reg, xor_next;
    logic        start_bad_reg, start_bad_next;
    logic        sum_bad_reg, sum_bad_next;
    logic [2:0]  hdr_sel;
    byte_t       count_inc;

    assign hdr_sel   = 3'(phase_reg - PH_HDR0);
    assign count_inc = count_reg + 8'd1;

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        hdr_next       = hdr_reg;
        xor_next       = xor_reg;
        start_bad_next = start_bad_reg;
        sum_bad_next   = sum_bad_reg;
        res_valid      = 1'b0;
        res.kind       = KIND_FRAME;
        res.data_byte  = 8'd0;
        res.byte_index = 8'd0;
        res.error_mask = 4'd0;

        case (phase_reg)
            PH_START: begin
                start_bad_next = (in_byte != start_byte_reg);
                sum_bad_next   = 1'b0;
                xor_next       = 8'd0;
                count_next     = 8'd0;
                len_next       = 16'd0;
                for (int i = 0; i < HDR_BYTES; i++) hdr_next[i] = 8'd0;
                phase_next     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_next   = {in_byte, 8'd0};
                xor_next   = xor_reg ^ in_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_next = {len_reg[15:8], in_byte};
                xor_next = xor_reg ^ in_byte;
                if ({len_reg[15:8], in_byte} > {8'd0, max_payload_reg}) begin
                    res_valid                = 1'b1;
                    res.error_mask[ERR_LONG]  = 1'b1;
                    res.error_mask[ERR_START] = start_bad_reg;
                    phase_next               = PH_START;
                end else begin
                    phase_next = PH_HDR0;
                end
            end
            PH_PAYLOAD: begin
                xor_next       = xor_reg ^ in_byte;
                res_valid      = 1'b1;
                res.kind       = KIND_PAYLOAD;
                res.data_byte  = in_byte;
                res.byte_index = count_reg;
                count_next     = count_inc;
                if ({8'd0, count_inc} >= len_reg) phase_next = PH_CHECK;
            end
            PH_CHECK: begin
                sum_bad_next = (in_byte != xor_reg);
                phase_next   = PH_END;
            end
            PH_END: begin
                res_valid                = 1'b1;
                res.error_mask[ERR_START] = start_bad_reg;
                res.error_mask[ERR_END]   = (in_byte != end_byte_reg);
                res.error_mask[ERR_SUM]   = sum_bad_reg;
                phase_next               = PH_START;
            end
            default: begin
                if (phase_reg >= PH_HDR0 && phase_reg <= PH_HDR5) begin
                    hdr_next[hdr_sel] = in_byte;
                    xor_next          = xor_reg ^ in_byte;
                    if (phase_reg == PH_HDR5)
                        phase_next = (len_reg == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    else
                        phase_next = phase_reg + 4'd1;
                end else begin
                    phase_next = PH_START;
                end
            end
        endcase

        // header and length as they stand after this word
        res.length        = len_next;
        res.cmd           = hdr_next[0];
        res.dev_id        = hdr_next[1];
        res.dev_address   = hdr_next[2];
        res.dev_channel   = hdr_next[3];
        res.mode_byte     = hdr_next[4];
        res.response_time = hdr_next[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg  <= START_BYTE_RST;
            end_byte_reg    <= END_BYTE_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_BYTE:  start_byte_reg  <= cfg_data;
                CFG_END_BYTE:    end_byte_reg    <= cfg_data;
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            count_reg     <= 8'd0;
            len_reg       <= 16'd0;
            xor_reg       <= 8'd0;
            start_bad_reg <= 1'b0;
            sum_bad_reg   <= 1'b0;
            for (int i = 0; i < HDR_BYTES; i++) hdr_reg[i] <= 8'd0;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            xor_reg       <= xor_next;
            start_bad_reg <= start_bad_next;
            sum_bad_reg   <= sum_bad_next;
            hdr_reg       <= hdr_next;
        end
    end

endmodule

// ----- rtl/sfd_out_reg.sv -----
// Result register between the parser and the output channel.
// Depends on sfd_pkg.
module sfd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  sfd_pkg::result_t res,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             free,
    output sfd_pkg::result_t m_res
);
    import sfd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // slot frees up in the same cycle its word is taken
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_ready) valid_next = 1'b0;
        if (load) valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load) res_reg <= res;
    end

endmodule

// ----- rtl/serial_frame_deframer.sv -----
// Serial frame deframer top level: config port, parser and result register.
// Depends on sfd_pkg, sfd_parser and sfd_out_reg.
//
// Takes one received byte per cycle while s_ready is high, and splits the
// stream into frames of start, 16-bit length, six header bytes, payload,
// XOR checksum and end byte. Every payload byte comes out as a word of kind
// 0 as it arrives; the end byte (or a length above max_payload, right at the
// low length byte) gives one word of kind 1 with the header fields and error
// mask. Each byte passes through the phase state machine into a single
// result register; s_ready is high while that register is empty or being
// read, so bytes flow back to back at one per cycle while words are taken.
// Config writes are always ready and take effect on the next byte.
module serial_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_byte_index,
    output logic [15:0] m_length,
    output logic [7:0]  m_cmd,
    output logic [7:0]  m_dev_id,
    output logic [7:0]  m_dev_address,
    output logic [7:0]  m_dev_channel,
    output logic [7:0]  m_mode_byte,
    output logic [7:0]  m_response_time,
    output logic [3:0]  m_error_mask
);
    import sfd_pkg::*;

    logic    in_accept;
    logic    res_valid;
    logic    slot_free;
    result_t res, m_res;

    assign cfg_ready = 1'b1;
    assign s_ready   = slot_free;
    assign in_accept = s_valid && slot_free;

    sfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (in_accept && res_valid),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .free    (slot_free),
        .m_res   (m_res)
    );

    assign m_kind          = m_res.kind;
    assign m_data_byte     = m_res.data_byte;
    assign m_byte_index    = m_res.byte_index;
    assign m_length        = m_res.length;
    assign m_cmd           = m_res.cmd;
    assign m_dev_id        = m_res.dev_id;
    assign m_dev_address   = m_res.dev_address;
    assign m_dev_channel   = m_res.dev_channel;
    assign m_mode_byte     = m_res.mode_byte;
    assign m_response_time = m_res.response_time;
    assign m_error_mask    = m_res.error_mask;

endmodule

// ----- verif/serial_frame_deframer_test.sv -----
// Self-checking testbench for serial_frame_deframer: random frames, noise and config sweeps.
// Depends on sfd_pkg and the serial_frame_deframer RTL; a built-in frame parser supplies
// the expected words.
module serial_frame_deframer_test;
    import sfd_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_BYTES = 160;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_START_BYTE;
    byte_t       cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    byte_t       s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    byte_t       m_data_byte;
    byte_t       m_byte_index;
    logic [15:0] m_length;
    byte_t       m_cmd;
    byte_t       m_dev_id;
    byte_t       m_dev_address;
    byte_t       m_dev_channel;
    byte_t       m_mode_byte;
    byte_t       m_response_time;
    logic [3:0]  m_error_mask;

    serial_frame_deframer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_byte_index   (m_byte_index),
        .m_length       (m_length),
        .m_cmd          (m_cmd),
        .m_dev_id       (m_dev_id),
        .m_dev_address  (m_dev_address),
        .m_dev_channel  (m_dev_channel),
        .m_mode_byte    (m_mode_byte),
        .m_response_time(m_response_time),
        .m_error_mask   (m_error_mask)
    );

    // opening frames: good zero-length frame, too-long length, bad start/sum/end with one byte
    byte_t opening_bytes[26] = '{
        8'h02, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h03,
        8'h02, 8'hFF, 8'h00,
        8'h00, 8'h00, 8'h01, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'hAB, 8'h00, 8'hFF
    };

    byte_t   rx_stream[$];
    result_t parsed_words[$];
    int      bytes_queued = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      fails = 0;
    int      quiet = 0;

    // parser state and register copies
    byte_t       start_val = START_BYTE_RST;
    byte_t       end_val = END_BYTE_RST;
    byte_t       max_len = MAX_PAYLOAD_RST;
    logic [3:0]  frame_phase;
    byte_t       pay_count;
    logic [15:0] pay_len;
    byte_t       hdr_bytes[HDR_BYTES];
    byte_t       xor_acc;
    logic        start_err;
    logic        sum_err;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_frame();
        sum_err = 1'b0;
        xor_acc = '0;
        pay_count = '0;
        pay_len = '0;
        foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    endfunction

    function automatic result_t header_word(input logic [3:0] err);
        result_t w;
        w = '0;
        w.kind = KIND_FRAME;
        w.length = pay_len;
        w.cmd = hdr_bytes[0];
        w.dev_id = hdr_bytes[1];
        w.dev_address = hdr_bytes[2];
        w.dev_channel = hdr_bytes[3];
        w.mode_byte = hdr_bytes[4];
        w.response_time = hdr_bytes[5];
        w.error_mask = err;
        return w;
    endfunction

    task automatic parse_byte(input byte_t b);
        result_t    w;
        logic [3:0] err;
        err = '0;
        case (frame_phase)
            PH_START: begin
                clear_frame();
                start_err = (b != start_val);
                frame_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                pay_len = {b, 8'h00};
                xor_acc ^= b;
                frame_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                pay_len = {pay_len[15:8], b};
                xor_acc ^= b;
                if (pay_len > max_len) begin
                    // header is still all zero here
                    err[ERR_LONG] = 1'b1;
                    err[ERR_START] = start_err;
                    parsed_words.push_back(header_word(err));
                    frame_phase = PH_START;
                end else begin
                    frame_phase = PH_HDR0;
                end
            end
            PH_PAYLOAD: begin
                xor_acc ^= b;
                w = header_word('0);
                w.kind = KIND_PAYLOAD;
                w.data_byte = b;
                w.byte_index = pay_count;
                parsed_words.push_back(w);
                pay_count = pay_count + 8'd1;
                if (16'(pay_count) >= pay_len) frame_phase = PH_CHECK;
            end
            PH_CHECK: begin
                sum_err = (b != xor_acc);
                frame_phase = PH_END;
            end
            PH_END: begin
                err[ERR_START] = start_err;
                err[ERR_END] = (b != end_val);
                err[ERR_SUM] = sum_err;
                parsed_words.push_back(header_word(err));
                frame_phase = PH_START;
            end
            default: begin
                if (frame_phase >= PH_HDR0 && frame_phase <= PH_HDR5) begin
                    hdr_bytes[frame_phase - PH_HDR0] = b;
                    xor_acc ^= b;
                    if (frame_phase == PH_HDR5)
                        frame_phase = (pay_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    else
                        frame_phase = frame_phase + 4'd1;
                end else begin
                    frame_phase = PH_START;
                end
            end
        endcase
    endtask

    function automatic string word_text(input result_t w);
        return $sformatf({"kind=%0d data=%02h idx=%0d len=%04h ",
                          "hdr=%02h %02h %02h %02h %02h %02h err=%04b"},
            w.kind, w.data_byte, w.byte_index, w.length, w.cmd, w.dev_id, w.dev_address,
            w.dev_channel, w.mode_byte, w.response_time, w.error_mask);
    endfunction

    // sender: one byte per handshake, valid held until taken
    always @(posedge aclk) begin : drive_rx
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_frame();
            start_err = 1'b0;
            frame_phase = PH_START;
        end else begin
            if (s_valid && s_ready) parse_byte(s_rx_byte);
            if (!s_valid || s_ready) begin
                if (rx_stream.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= rx_stream.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch_results
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_data_byte, m_byte_index, m_length, m_cmd, m_dev_id,
                       m_dev_address, m_dev_channel, m_mode_byte, m_response_time,
                       m_error_mask};
                if (parsed_words.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected word: %s", word_text(got));
                end else begin
                    want = parsed_words.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("word mismatch");
                            $display("  expected %s", word_text(want));
                            $display("  actual   %s", word_text(got));
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("serial_frame_deframer regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input byte_t val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_BYTE:  start_val = val;
            CFG_END_BYTE:    end_val = val;
            CFG_MAX_PAYLOAD: max_len = val;
            default: ;
        endcase
    endtask

    // all bytes taken and all words out, then let the result register settle
    task automatic drain();
        do @(negedge aclk); while (rx_stream.size() != 0 || s_valid || parsed_words.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // keep limits how many bytes of the frame go out (cut frames run into the next one)
    task automatic push_frame(input int len, input bit bad_start, input bit bad_sum,
                              input bit bad_end, input int keep);
        byte_t f[$];
        byte_t x;
        byte_t b;
        int    i;
        f.push_back(bad_start ? start_val ^ byte_t'($urandom_range(1, 255)) : start_val);
        f.push_back(len[15:8]);
        f.push_back(len[7:0]);
        x = len[15:8] ^ len[7:0];
        if (len <= int'(max_len)) begin
            for (i = 0; i < HDR_BYTES + len; i++) begin
                b = byte_t'($urandom);
                f.push_back(b);
                x ^= b;
            end
            f.push_back(bad_sum ? x ^ byte_t'($urandom_range(1, 255)) : x);
            f.push_back(bad_end ? end_val ^ byte_t'($urandom_range(1, 255)) : end_val);
        end
        for (i = 0; i < f.size() && i < keep; i++) begin
            rx_stream.push_back(f[i]);
            bytes_queued++;
        end
    endtask

    function automatic int short_len();
        int cap;
        cap = (max_len < 8) ? int'(max_len) : 8;
        return ($urandom_range(0, 3) != 0) ? $urandom_range(0, cap)
                                           : $urandom_range(0, int'(max_len));
    endfunction

    initial begin : run
        int    p;
        int    r;
        int    len;
        int    target;
        byte_t s;
        byte_t e;
        byte_t mx;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        for (p = 0; p < 9; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: begin s = 8'h00; e = 8'hFF; mx = 8'd0;   end
                    2: begin s = 8'hFF; e = 8'h00; mx = 8'd255; end
                    4: begin s = 8'hA5; e = 8'h5A; mx = 8'd1;   end
                    7: begin s = START_BYTE_RST; e = END_BYTE_RST; mx = MAX_PAYLOAD_RST; end
                    default: begin
                        s = byte_t'($urandom);
                        e = byte_t'($urandom);
                        mx = byte_t'($urandom_range(0, 255));
                    end
                endcase
                write_reg(CFG_START_BYTE, s);
                write_reg(CFG_END_BYTE, e);
                write_reg(CFG_MAX_PAYLOAD, mx);
            end
            @(negedge aclk);
            tx_idle_pct <= (p < 3) ? 35 : (p < 6) ? 79 : 0;
            rx_idle_pct <= (p < 3) ? 79 : (p < 6) ? 35 : 0;
            if (p == 0) begin
                foreach (opening_bytes[i]) rx_stream.push_back(opening_bytes[i]);
            end
            target = bytes_queued + PHASE_BYTES;
            // one frame at the full allowed length per setting
            push_frame(int'(max_len), 1'b0, 1'b0, 1'b0, 1 << 20);
            while (bytes_queued < target) begin
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    push_frame(short_len(), $urandom_range(0, 11) == 0,
                               $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0, 1 << 20);
                end else if (r < 84) begin
                    len = ($urandom_range(0, 1) != 0) ? int'(max_len) + 1
                                                      : $urandom_range(int'(max_len) + 1, 65535);
                    push_frame(len, $urandom_range(0, 3) == 0, 1'b0, 1'b0, 1 << 20);
                end else if (r < 92) begin
                    push_frame(short_len(), 1'b0, 1'b0, 1'b0, $urandom_range(1, 10));
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        rx_stream.push_back(byte_t'($urandom));
                        bytes_queued++;
                    end
                end
            end
        end
        drain();
        repeat (8) @(posedge aclk);
        if (fails == 0)
            $display("serial_frame_deframer regression: pass");
        else
            $display("serial_frame_deframer regression: fail");
        $finish;
    end

endmodule

// ----- serial_frame_deframer.f -----
rtl/sfd_pkg.sv
rtl/sfd_parser.sv
rtl/sfd_out_reg.sv
rtl/serial_frame_deframer.sv
verif/serial_frame_deframer_test.sv
